// ----- sv/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the segment crossing tester
// Word layouts, sequencer states, verdict and orientation codes, widths.
// ----------------------------------------------------------------------------
package sct_pkg;

	// Vertex store geometry
	localparam int VERTEX_COUNT = 256;
	localparam int VADDR_W      = $clog2(VERTEX_COUNT);

	// Field and arithmetic widths
	localparam int IDX_W   = 8;
	localparam int COORD_W = 24;
	localparam int VERT_W  = 2 * COORD_W;
	localparam int EPS_W   = 20;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int VAL_W   = PROD_W + 1;

	// Sequencer counts
	localparam int PT_COUNT = 4;
	localparam int CNT_W    = 4;
	localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(PT_COUNT);
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(9);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_EPS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COLLINEAR_EPS = CFG_IDX_W'(1);
	localparam logic [EPS_W-1:0] PARALLEL_EPS_RST  = EPS_W'(66);
	localparam logic [EPS_W-1:0] COLLINEAR_EPS_RST = EPS_W'(7);

	// Item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		VD_CROSS    = 2'd0,
		VD_PARALLEL = 2'd1,
		VD_SHARED   = 2'd2,
		VD_NONE     = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_CW  = 2'd1,
		ORI_CCW = 2'd2
	} orient_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MULT,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                      opcode;
		logic [IDX_W-1:0]          write_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic [IDX_W-1:0]          first_start;
		logic [IDX_W-1:0]          first_end;
		logic [IDX_W-1:0]          second_start;
		logic [IDX_W-1:0]          second_end;
	} item_t;

	typedef struct packed {
		logic       crosses;
		logic [1:0] verdict;
	} result_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic             busy;
		logic             start;
		logic             ld_issue;
		logic             ld_capture;
		logic [1:0]       ld_slot;
		logic             mul_go;
		logic [CNT_W-1:0] mul_sel;
		logic             finish;
	} ctl_t;

endpackage

// ----- sv/sct_ram.sv -----
// ----------------------------------------------------------------------------
// sct_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/sct_ctrl.sv -----
// ----------------------------------------------------------------------------
// sct_ctrl: query sequencer
// Steps a query through vertex loads, ten shared multiplies and the result.
// ----------------------------------------------------------------------------
module sct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          query_go,
	input  logic          res_free,
	output sct_pkg::ctl_t ctl
);
	import sct_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (query_go) state_d = ST_LOAD;
			ST_LOAD:   if (cnt_q == LOAD_LAST) state_d = ST_MULT;
			ST_MULT:   if (cnt_q == MUL_LAST) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: if (res_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl = '0;
		ctl.busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctl.start = query_go;
			end
			ST_LOAD: begin
				ctl.ld_issue   = (cnt_q < LOAD_LAST);
				ctl.ld_capture = (cnt_q != '0);
				ctl.ld_slot    = 2'(cnt_q - CNT_W'(1));
			end
			ST_MULT: begin
				ctl.mul_go  = 1'b1;
				ctl.mul_sel = cnt_q;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_LOAD || state_q == ST_MULT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Counter never runs past the last step of its phase
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (cnt_q <= LOAD_LAST))
		else $error("load counter overran");
	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |-> (cnt_q <= MUL_LAST))
		else $error("multiply counter overran");
	a_capture_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_capture |-> $past(ctl.ld_issue))
		else $error("vertex capture without a read issued");

endmodule

// ----- sv/sct_datapath.sv -----
// ----------------------------------------------------------------------------
// sct_datapath: vertex registers and the shared multiply-subtract unit
// Holds the four points, runs one signed multiply per step and classifies.
// ----------------------------------------------------------------------------
module sct_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sct_pkg::ctl_t               ctl,
	input  sct_pkg::item_t              item,
	input  logic [sct_pkg::EPS_W-1:0]   parallel_eps,
	input  logic [sct_pkg::EPS_W-1:0]   collinear_eps,
	input  logic [sct_pkg::VERT_W-1:0]  rdata,
	output logic [sct_pkg::VADDR_W-1:0] raddr,
	output sct_pkg::verdict_t           verdict
);
	import sct_pkg::*;

	logic [IDX_W-1:0]          idx_sh_q [PT_COUNT];
	logic                      shared_q;
	logic                      rng_s1;
	logic signed [COORD_W-1:0] pts_x_q [PT_COUNT];
	logic signed [COORD_W-1:0] pts_y_q [PT_COUNT];

	logic signed [COORD_W-1:0] ua, ub, va, vb;
	logic signed [DIFF_W-1:0]  da, db;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [CNT_W-1:0]          tag_s1;
	logic                      pv_s1;
	logic signed [PROD_W-1:0]  acc_q;

	logic signed [VAL_W-1:0]   val;
	logic [VAL_W-1:0]          mag;
	logic                      below_par;
	orient_t                   ori_c;
	logic                      par_q;
	orient_t                   ori_q [PT_COUNT];

	// Read address comes from the head of the index shift line
	assign raddr = VADDR_W'(idx_sh_q[0]);

	// Latch indices, shift them out one read at a time, capture points
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			idx_sh_q[0] <= item.first_start;
			idx_sh_q[1] <= item.first_end;
			idx_sh_q[2] <= item.second_start;
			idx_sh_q[3] <= item.second_end;
			shared_q <= (item.first_start == item.second_start) ||
			            (item.first_start == item.second_end) ||
			            (item.first_end == item.second_start) ||
			            (item.first_end == item.second_end);
		end else if (ctl.ld_issue) begin
			for (int i = 0; i < PT_COUNT - 1; i++) begin
				idx_sh_q[i] <= idx_sh_q[i+1];
			end
		end
		rng_s1 <= (32'(idx_sh_q[0]) < VERTEX_COUNT);
		if (ctl.ld_capture) begin
			pts_x_q[ctl.ld_slot] <= rng_s1 ? rdata[COORD_W-1:0] : '0;
			pts_y_q[ctl.ld_slot] <= rng_s1 ? rdata[VERT_W-1:COORD_W] : '0;
		end
	end

	// Operand select: each step multiplies (ua - ub) by (va - vb).
	// Slots: 0 first start, 1 first end, 2 second start, 3 second end.
	always_comb begin
		ua = '0;
		ub = '0;
		va = '0;
		vb = '0;
		unique case (ctl.mul_sel)
			// direction cross product
			4'd0: begin ua = pts_x_q[0]; ub = pts_x_q[1]; va = pts_y_q[2]; vb = pts_y_q[3]; end
			4'd1: begin ua = pts_y_q[0]; ub = pts_y_q[1]; va = pts_x_q[2]; vb = pts_x_q[3]; end
			// first segment against second start
			4'd2: begin ua = pts_y_q[1]; ub = pts_y_q[0]; va = pts_x_q[2]; vb = pts_x_q[1]; end
			4'd3: begin ua = pts_x_q[1]; ub = pts_x_q[0]; va = pts_y_q[2]; vb = pts_y_q[1]; end
			// first segment against second end
			4'd4: begin ua = pts_y_q[1]; ub = pts_y_q[0]; va = pts_x_q[3]; vb = pts_x_q[1]; end
			4'd5: begin ua = pts_x_q[1]; ub = pts_x_q[0]; va = pts_y_q[3]; vb = pts_y_q[1]; end
			// second segment against first start
			4'd6: begin ua = pts_y_q[3]; ub = pts_y_q[2]; va = pts_x_q[0]; vb = pts_x_q[3]; end
			4'd7: begin ua = pts_x_q[3]; ub = pts_x_q[2]; va = pts_y_q[0]; vb = pts_y_q[3]; end
			// second segment against first end
			4'd8: begin ua = pts_y_q[3]; ub = pts_y_q[2]; va = pts_x_q[1]; vb = pts_x_q[3]; end
			4'd9: begin ua = pts_x_q[3]; ub = pts_x_q[2]; va = pts_y_q[1]; vb = pts_y_q[3]; end
			default: begin
			end
		endcase
		da = DIFF_W'(ua) - DIFF_W'(ub);
		db = DIFF_W'(va) - DIFF_W'(vb);
		prod_c = PROD_W'(da) * PROD_W'(db);
	end

	// Register the product with its step tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= ctl.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		tag_s1  <= ctl.mul_sel;
	end

	// Subtract the pair and classify
	always_comb begin
		val       = VAL_W'(acc_q) - VAL_W'(prod_s1);
		mag       = val[VAL_W-1] ? VAL_W'(-val) : VAL_W'(val);
		below_par = (mag < VAL_W'(parallel_eps));
		if (mag < VAL_W'(collinear_eps)) begin
			ori_c = ORI_COL;
		end else if (!val[VAL_W-1] && val != '0) begin
			ori_c = ORI_CW;
		end else begin
			ori_c = ORI_CCW;
		end
	end

	// Hold first product of a pair; store the outcome on the second
	always_ff @(posedge clk) begin
		if (pv_s1 && !tag_s1[0]) begin
			acc_q <= prod_s1;
		end
		if (pv_s1 && tag_s1[0]) begin
			unique case (tag_s1[CNT_W-1:1])
				3'd0:    par_q    <= below_par;
				3'd1:    ori_q[0] <= ori_c;
				3'd2:    ori_q[1] <= ori_c;
				3'd3:    ori_q[2] <= ori_c;
				3'd4:    ori_q[3] <= ori_c;
				default: begin
				end
			endcase
		end
	end

	// Parallel wins over shared end point, then the orientation pairs
	always_comb begin
		if (par_q) begin
			verdict = VD_PARALLEL;
		end else if (shared_q) begin
			verdict = VD_SHARED;
		end else if (ori_q[0] != ori_q[1] && ori_q[2] != ori_q[3]) begin
			verdict = VD_CROSS;
		end else begin
			verdict = VD_NONE;
		end
	end

endmodule

// ----- sv/segment_crossing_tester_top.sv -----
// ----------------------------------------------------------------------------
// segment_crossing_tester_top: 2D segment crossing test over a vertex store
// Vertex writes and segment queries share one input channel.
// ----------------------------------------------------------------------------
// A query's result is valid after its vertex loads, its multiplies, a drain
// state and a finish state. The input channel stalls during a query, which
// makes ten passes through the single multiplier plus four serial reads
// through the one read port of the vertex RAM; writes are taken while idle.
// Reset clears control and loads parallel_eps = 66 and collinear_eps = 7;
// the vertex RAM is not cleared and reads garbage until each slot is written.
module segment_crossing_tester_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  sct_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output sct_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [sct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sct_pkg::EPS_W-1:0]     cfg_data
);
	import sct_pkg::*;

	ctl_t             ctl;
	logic             item_acc;
	logic             query_go;
	logic             res_free;
	logic             ram_we;
	logic [VADDR_W-1:0] raddr;
	logic [VERT_W-1:0]  rdata;
	verdict_t         verdict;
	logic [EPS_W-1:0] parallel_eps_q;
	logic [EPS_W-1:0] collinear_eps_q;
	logic             result_valid_q;
	result_t          result_q;

	// Input handshake
	assign item_stall = ctl.busy;
	assign item_acc   = item_valid && !item_stall;
	assign query_go   = item_acc && (item.opcode == OP_QUERY);
	assign ram_we     = item_acc && (item.opcode == OP_WRITE) &&
	                    (32'(item.write_index) < VERTEX_COUNT);
	assign res_free   = !result_valid_q || !result_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parallel_eps_q  <= PARALLEL_EPS_RST;
			collinear_eps_q <= COLLINEAR_EPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PARALLEL_EPS:  parallel_eps_q  <= cfg_data;
				CFG_COLLINEAR_EPS: collinear_eps_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sct_ram #(
		.WIDTH(VERT_W),
		.DEPTH(VERTEX_COUNT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(VADDR_W'(item.write_index)),
		.wdata({item.coord_y, item.coord_x}),
		.raddr(raddr),
		.rdata(rdata)
	);

	sct_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.query_go(query_go),
		.res_free(res_free),
		.ctl     (ctl)
	);

	sct_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.item         (item),
		.parallel_eps (parallel_eps_q),
		.collinear_eps(collinear_eps_q),
		.rdata        (rdata),
		.raddr        (raddr),
		.verdict      (verdict)
	);

	// Output word register: load when finished and free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.finish && res_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && res_free) begin
			result_q.crosses <= (verdict == VD_CROSS);
			result_q.verdict <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A new word appears only right after the sequencer finishes
	a_rise_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl.finish))
		else $error("result word without a finished query");
	// The crossing flag agrees with the verdict code
	a_crosses_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.crosses == (result.verdict == VD_CROSS)))
		else $error("crossing flag disagrees with verdict");
	// A stalled result word stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result word changed");

endmodule

// ----- dv/crossing_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossing_checker: result checker for the segment crossing tester
// Watches the item, result and register ports, keeps a shadow vertex store and
// threshold copies, predicts the verdict of every accepted query word and
// compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module crossing_checker
	import sct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  item_t                item,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EPS_W-1:0]     cfg_data,
	output int                   errors,
	output int                   outstanding
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [VAL_W-1:0]  val_t;

	point_t           vertex_copy [VERTEX_COUNT];
	logic [EPS_W-1:0] parallel_eps  = PARALLEL_EPS_RST;
	logic [EPS_W-1:0] collinear_eps = COLLINEAR_EPS_RST;
	result_t          verdicts_due [$];
	result_t          due;

	// Coordinate difference, one bit wider than a coordinate
	function automatic diff_t span(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
		diff_t d;
		d = a - b;
		return d;
	endfunction

	// Scalar z-component of the cross product of (ax, ay) and (bx, by)
	function automatic val_t wedge(diff_t ax, diff_t ay, diff_t bx, diff_t by);
		val_t lhs;
		val_t rhs;
		lhs = ax * by;
		rhs = ay * bx;
		return lhs - rhs;
	endfunction

	function automatic logic [VAL_W-1:0] magnitude(val_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Turn direction of p -> q -> r, collinear inside the threshold
	function automatic orient_t turn(point_t p, point_t q, point_t r);
		val_t v;
		v = wedge(span(r.x, q.x), span(r.y, q.y), span(q.x, p.x), span(q.y, p.y));
		if (magnitude(v) < collinear_eps)
			return ORI_COL;
		return (v > 0) ? ORI_CW : ORI_CCW;
	endfunction

	// Verdict on the two segments named by a query word
	function automatic result_t judge_segments(item_t word);
		point_t   p1;
		point_t   q1;
		point_t   p2;
		point_t   q2;
		val_t     cr;
		verdict_t v;
		result_t  r;
		p1 = vertex_copy[word.first_start];
		q1 = vertex_copy[word.first_end];
		p2 = vertex_copy[word.second_start];
		q2 = vertex_copy[word.second_end];
		cr = wedge(span(p1.x, q1.x), span(p1.y, q1.y), span(p2.x, q2.x), span(p2.y, q2.y));
		if (magnitude(cr) < parallel_eps)
			v = VD_PARALLEL;
		else if (word.first_start == word.second_start || word.first_start == word.second_end ||
			word.first_end == word.second_start || word.first_end == word.second_end)
			v = VD_SHARED;
		else if (turn(p1, q1, p2) != turn(p1, q1, q2) && turn(p2, q2, p1) != turn(p2, q2, q1))
			v = VD_CROSS;
		else
			v = VD_NONE;
		r.crosses = (v == VD_CROSS);
		r.verdict = v;
		return r;
	endfunction

	// Track the ports at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parallel_eps  = PARALLEL_EPS_RST;
			collinear_eps = COLLINEAR_EPS_RST;
			verdicts_due.delete();
			errors        = 0;
			outstanding   = 0;
		end else begin
			// compare the result word leaving the block
			if (result_valid && !result_stall) begin
				if (verdicts_due.size() == 0) begin
					errors++;
					$display("%t: unexpected result: expected none, got crosses=%0d verdict=%0d",
						$time, result.crosses, result.verdict);
				end else begin
					due = verdicts_due.pop_front();
					if (result.crosses !== due.crosses) begin
						errors++;
						$display("%t: crosses mismatch: expected %0d, got %0d",
							$time, due.crosses, result.crosses);
					end
					if (result.verdict !== due.verdict) begin
						errors++;
						$display("%t: verdict mismatch: expected %0d, got %0d",
							$time, due.verdict, result.verdict);
					end
				end
			end

			// follow threshold writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_PARALLEL_EPS:  parallel_eps  = cfg_data;
					CFG_COLLINEAR_EPS: collinear_eps = cfg_data;
					default: ;
				endcase
			end

			// store a vertex or predict a query
			if (item_valid && !item_stall) begin
				if (item.opcode == OP_WRITE)
					vertex_copy[item.write_index] = '{x: item.coord_x, y: item.coord_y};
				else
					verdicts_due.insert(verdicts_due.size(), judge_segments(item));
			end

			outstanding = verdicts_due.size();
		end
	end

endmodule

// ----- dv/segment_crossing_tester_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_crossing_tester_top_tb: testbench of the segment crossing tester
// Loads vertices and issues segment queries, first a directed set of shapes
// and then random words, under several threshold settings, mostly with random
// gaps and back-pressure; the crossing checker predicts and compares every result.
// ----------------------------------------------------------------------------
module segment_crossing_tester_top_tb;
	import sct_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 24;
	localparam int PRESSURE_CYCLES = 300;
	localparam logic [EPS_W-1:0] EPS_MAX = '1;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_PARALLEL_EPS;
	logic [EPS_W-1:0]     cfg_data     = '0;

	int errors;
	int outstanding;
	int cycle_count = 0;

	bit quiet    = 1'b0;
	bit hold_req = 1'b0;

	bit               slot_written [VERTEX_COUNT];
	logic [IDX_W-1:0] written_slots [$];

	segment_crossing_tester_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	crossing_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side stalls: one long hold on request, else random bursts
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	// Offer one word, sometimes after a random gap, and hold it until taken
	task automatic offer(input item_t w);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Vertex write; the query fields carry noise
	task automatic write_vertex(input logic [IDX_W-1:0] slot, input int x, input int y);
		logic [95:0] noise;
		item_t       w;
		noise         = {$urandom, $urandom, $urandom};
		w             = noise[$bits(item_t)-1:0];
		w.opcode      = OP_WRITE;
		w.write_index = slot;
		w.coord_x     = x[COORD_W-1:0];
		w.coord_y     = y[COORD_W-1:0];
		offer(w);
		if (!slot_written[slot]) begin
			slot_written[slot] = 1'b1;
			written_slots.insert(written_slots.size(), slot);
		end
	endtask

	// Segment query; the vertex write fields carry noise
	task automatic query(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
		input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
		logic [95:0] noise;
		item_t       w;
		noise          = {$urandom, $urandom, $urandom};
		w              = noise[$bits(item_t)-1:0];
		w.opcode       = OP_QUERY;
		w.first_start  = a;
		w.first_end    = b;
		w.second_start = c;
		w.second_end   = d;
		offer(w);
	endtask

	// Coordinate mix: coarse grid, fine area, near-zero, full range, extremes
	function automatic int pick_coord();
		int mode;
		int t;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			t = $urandom_range(0, 8);
			return (t - 4) * 256;
		end else if (mode < 5) begin
			t = $urandom_range(0, 10240);
			return t - 5120;
		end else if (mode < 7) begin
			t = $urandom_range(0, 16);
			return t - 8;
		end else if (mode < 9) begin
			return $urandom;
		end
		case ($urandom_range(0, 3))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] any_slot();
		return written_slots[$urandom_range(0, written_slots.size() - 1)];
	endfunction

	// Random words, mostly queries over written slots
	task automatic random_items(input int count);
		int               pick;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] d;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (written_slots.size() < 4 || pick < 35) begin
				write_vertex(IDX_W'($urandom_range(0, VERTEX_COUNT - 1)), pick_coord(),
					pick_coord());
			end else begin
				a = any_slot();
				b = any_slot();
				c = any_slot();
				d = any_slot();
				// force shared ends and zero-length segments now and then
				if (pick < 45)
					c = ($urandom_range(0, 1) == 0) ? a : b;
				else if (pick < 50)
					b = a;
				else if (pick < 55)
					d = b;
				query(a, b, c, d);
			end
		end
	endtask

	// Drop valid and wait until every result is out and the block is quiet
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both thresholds while idle
	task automatic retune(input logic [EPS_W-1:0] par, input logic [EPS_W-1:0] col);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PARALLEL_EPS;
		cfg_data  <= par;
		@(posedge clk);
		cfg_index <= CFG_COLLINEAR_EPS;
		cfg_data  <= col;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed shapes under reset thresholds
		write_vertex(8'd0, 0, 0);
		write_vertex(8'd1, 2560, 2560);
		write_vertex(8'd2, 0, 2560);
		write_vertex(8'd3, 2560, 0);
		write_vertex(8'd4, 1280, 1280);
		write_vertex(8'd5, 5120, 5120);
		write_vertex(8'd6, 5120, 0);
		write_vertex(8'd7, -256, -256);
		write_vertex(8'd255, -8388608, 8388607);
		write_vertex(8'd254, 8388607, -8388608);
		query(8'd0, 8'd1, 8'd2, 8'd3);     // plain crossing
		query(8'd0, 8'd1, 8'd4, 8'd5);     // collinear overlap, parallel
		query(8'd0, 8'd2, 8'd3, 8'd6);     // apart, no crossing
		query(8'd0, 8'd1, 8'd1, 8'd6);     // shared end point
		query(8'd0, 8'd0, 8'd2, 8'd3);     // zero-length segment
		query(8'd0, 8'd1, 8'd1, 8'd5);     // parallel wins over shared
		query(8'd2, 8'd3, 8'd0, 8'd4);     // end point touching the other segment
		query(8'd255, 8'd254, 8'd7, 8'd1); // extreme coordinates, crossing
		query(8'd255, 8'd254, 8'd0, 8'd1); // extreme coordinates, apart
		query(8'd255, 8'd254, 8'd2, 8'd3); // extreme coordinates, parallel

		// random phase with one long result hold
		hold_req = 1'b1;
		random_items(500);

		retune('0, '0);
		random_items(350);

		retune(EPS_MAX, EPS_MAX);
		random_items(300);

		retune(EPS_W'($urandom_range(0, 65536)), EPS_W'($urandom_range(0, 4096)));
		random_items(350);

		// last part without gaps or stalls
		quiet = 1'b1;
		retune(PARALLEL_EPS_RST, COLLINEAR_EPS_RST);
		random_items(400);

		drain();
		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sct_pkg.sv
sv/sct_ram.sv
sv/sct_ctrl.sv
sv/sct_datapath.sv
sv/segment_crossing_tester_top.sv
dv/crossing_checker.sv
dv/segment_crossing_tester_top_tb.sv
